[sv/asf1d_pkg.sv]
// Package for the 1-D arrive follower: widths, register map, microcode ROM.
`timescale 1ns / 1ps

package asf1d_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int SPEED_W = 31;
	localparam int DAMP_W  = 16;
	localparam int POS_W   = 32;
	localparam int IDX_W   = 2;
	localparam int UPC_W   = 4;

	localparam logic [IDX_W-1:0] REG_MAX_SPEED = 2'd0;
	localparam logic [IDX_W-1:0] REG_MAX_FORCE = 2'd1;
	localparam logic [IDX_W-1:0] REG_DAMPING   = 2'd2;

	localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 31'd131072;
	localparam logic [SPEED_W-1:0] MAX_FORCE_RST = 31'd32768;
	localparam logic [DAMP_W-1:0]  DAMPING_RST   = 16'd50;

	typedef enum logic [3:0] {
		OP_LATCH,
		OP_RESTART,
		OP_ERR,
		OP_MUL,
		OP_DIVINIT,
		OP_DIVSTEP,
		OP_DESRAMP,
		OP_DESMAX,
		OP_STEER,
		OP_VEL,
		OP_POS,
		OP_SNAP,
		OP_OUT
	} op_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_IN_VALID,
		COND_ERR_ZERO,
		COND_NO_RAMP,
		COND_DIV_MORE,
		COND_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [UPC_W-1:0] nxt_t;   // taken when cond holds
		logic [UPC_W-1:0] nxt_f;
	} ucode_t;

	localparam logic [UPC_W-1:0] S_WAIT    = 4'd0;
	localparam logic [UPC_W-1:0] S_RESTART = 4'd1;
	localparam logic [UPC_W-1:0] S_ERR     = 4'd2;
	localparam logic [UPC_W-1:0] S_MUL     = 4'd3;
	localparam logic [UPC_W-1:0] S_DIVINIT = 4'd4;
	localparam logic [UPC_W-1:0] S_DIVSTEP = 4'd5;
	localparam logic [UPC_W-1:0] S_DESRAMP = 4'd6;
	localparam logic [UPC_W-1:0] S_DESMAX  = 4'd7;
	localparam logic [UPC_W-1:0] S_STEER   = 4'd8;
	localparam logic [UPC_W-1:0] S_VEL     = 4'd9;
	localparam logic [UPC_W-1:0] S_POS     = 4'd10;
	localparam logic [UPC_W-1:0] S_SNAP    = 4'd11;
	localparam logic [UPC_W-1:0] S_OUT     = 4'd12;

	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
		ucode_t w;
		unique case (addr)
			S_WAIT:    w = '{OP_LATCH,   COND_IN_VALID, S_RESTART, S_WAIT};
			S_RESTART: w = '{OP_RESTART, COND_ALWAYS,   S_ERR,     S_ERR};
			S_ERR:     w = '{OP_ERR,     COND_ALWAYS,   S_MUL,     S_MUL};
			S_MUL:     w = '{OP_MUL,     COND_ERR_ZERO, S_SNAP,    S_DIVINIT};
			S_DIVINIT: w = '{OP_DIVINIT, COND_NO_RAMP,  S_DESMAX,  S_DIVSTEP};
			S_DIVSTEP: w = '{OP_DIVSTEP, COND_DIV_MORE, S_DIVSTEP, S_DESRAMP};
			S_DESRAMP: w = '{OP_DESRAMP, COND_ALWAYS,   S_STEER,   S_STEER};
			S_DESMAX:  w = '{OP_DESMAX,  COND_ALWAYS,   S_STEER,   S_STEER};
			S_STEER:   w = '{OP_STEER,   COND_ALWAYS,   S_VEL,     S_VEL};
			S_VEL:     w = '{OP_VEL,     COND_ALWAYS,   S_POS,     S_POS};
			S_POS:     w = '{OP_POS,     COND_ALWAYS,   S_OUT,     S_OUT};
			S_SNAP:    w = '{OP_SNAP,    COND_ALWAYS,   S_OUT,     S_OUT};
			S_OUT:     w = '{OP_OUT,     COND_OUT_FREE, S_WAIT,    S_OUT};
			default:   w = '{OP_ERR,     COND_ALWAYS,   S_WAIT,    S_WAIT};
		endcase
		return w;
	endfunction

endpackage

[sv/arrive_steering_follower_1d.sv]
// Top level: microcoded 1-D arrive steering follower in signed fixed point.
`timescale 1ns / 1ps

// One item is one tick of an arrive follower: position and velocity in signed
// fixed point with FRACTION_BITS fraction bits. A small microcode ROM steps a
// shared datapath, so a new item is taken only after the last one has loaded
// its result. When the target is inside the damping distance the 31-step
// restoring divider computes max_speed*|error|/distance; outside the ramp the
// divider is skipped, and when the error is zero the position snaps to the
// target. The result sits in an output register, so the next item is
// taken while it waits.
// Configuration is accepted in every cycle; write it only while idle.
module arrive_steering_follower_1d #(
	parameter int FRACTION_BITS = asf1d_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [asf1d_pkg::POS_W-1:0]  target_position,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [asf1d_pkg::POS_W-1:0]  position_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [asf1d_pkg::IDX_W-1:0]         cfg_index,
	input  logic [asf1d_pkg::SPEED_W-1:0]       cfg_data
);

	localparam int PW    = asf1d_pkg::POS_W;
	localparam int SW    = asf1d_pkg::SPEED_W;
	localparam int DmW   = asf1d_pkg::DAMP_W;
	localparam int DdW   = DmW + FRACTION_BITS;
	localparam int ErrW  = PW + 1;
	localparam int ProdW = SW + ErrW;
	localparam int QW    = SW;
	localparam int CmpW  = DdW + ErrW;
	localparam int CntW  = $clog2(QW + 1);

	asf1d_pkg::ucode_t uw;

	logic [asf1d_pkg::UPC_W-1:0] upc_q;
	logic [SW-1:0]               ms_q, mf_q;
	logic [DmW-1:0]              dd_q;
	logic signed [PW-1:0]        pos_q, vel_q;
	logic signed [PW-1:0]        target_q, des_q, steer_q, out_q;
	logic                        restart_q, out_valid_q;
	logic signed [ErrW-1:0]      err_q;
	logic [ProdW-1:0]            prod_q;
	logic [DdW-1:0]              rem_q;
	logic [QW-1:0]               shr_q, quo_q;
	logic [CntW-1:0]             cnt_q;

	logic [ErrW-1:0]             aerr;
	logic [DdW-1:0]              dd_full;
	logic                        no_ramp, err_zero, div_more, out_free, cond_hit;
	logic [CmpW-1:0]             prod_hi_ext;
	logic [DdW:0]                div_try, div_sub;
	logic                        div_ge;
	logic [SW-1:0]               des_mag;
	logic signed [PW-1:0]        des_next;
	logic signed [ErrW-1:0]      steer_raw, steer_lim, vel_raw, vel_lim, pos_raw;
	logic [ErrW-1:0]             steer_abs, vel_abs;
	logic signed [ErrW-1:0]      mf_ext, ms_ext;
	logic signed [PW-1:0]        pos_next;
	logic                        in_xfer;

	assign uw = asf1d_pkg::ucode_rom(upc_q);

	assign in_ready     = (uw.op == asf1d_pkg::OP_LATCH);
	assign in_xfer      = in_valid && in_ready;
	assign out_valid    = out_valid_q;
	assign position_out = out_q;
	assign cfg_ready    = 1'b1;

	// error magnitude and ramp decision
	assign aerr     = err_q[ErrW-1] ? ErrW'(-err_q) : ErrW'(err_q);
	assign dd_full  = {dd_q, {FRACTION_BITS{1'b0}}};
	assign err_zero = (err_q == '0);
	assign no_ramp  = (dd_q == '0) || (CmpW'(aerr) >= CmpW'(dd_full));

	// restoring divider: product >> QW is below the divisor on the ramp path
	assign prod_hi_ext = CmpW'(prod_q[ProdW-1:QW]);
	assign div_try     = {rem_q, shr_q[QW-1]};
	assign div_ge      = (div_try >= {1'b0, dd_full});
	assign div_sub     = div_try - {1'b0, dd_full};
	assign div_more    = (cnt_q != CntW'(1));

	// desired speed takes the sign of the error
	assign des_mag  = (uw.op == asf1d_pkg::OP_DESRAMP) ? quo_q : ms_q;
	assign des_next = err_q[ErrW-1] ? -$signed({1'b0, des_mag}) : $signed({1'b0, des_mag});

	assign mf_ext = $signed({2'b00, mf_q});
	assign ms_ext = $signed({2'b00, ms_q});

	// a zero raw value only reaches the clamp when the limit is zero
	assign steer_raw = {des_q[PW-1], des_q} - {vel_q[PW-1], vel_q};
	assign steer_abs = steer_raw[ErrW-1] ? ErrW'(-steer_raw) : ErrW'(steer_raw);
	assign steer_lim = (steer_abs >= ErrW'(mf_q)) ?
		(steer_raw[ErrW-1] ? -mf_ext : mf_ext) : steer_raw;

	assign vel_raw = {vel_q[PW-1], vel_q} + {steer_q[PW-1], steer_q};
	assign vel_abs = vel_raw[ErrW-1] ? ErrW'(-vel_raw) : ErrW'(vel_raw);
	assign vel_lim = (vel_abs >= ErrW'(ms_q)) ?
		(vel_raw[ErrW-1] ? -ms_ext : ms_ext) : vel_raw;

	assign pos_raw  = {pos_q[PW-1], pos_q} + {vel_q[PW-1], vel_q};
	assign pos_next = (pos_raw[ErrW-1] != pos_raw[PW-1]) ?
		(pos_raw[ErrW-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}}) :
		pos_raw[PW-1:0];

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		case (uw.cond)
			asf1d_pkg::COND_ALWAYS:   cond_hit = 1'b1;
			asf1d_pkg::COND_IN_VALID: cond_hit = in_valid;
			asf1d_pkg::COND_ERR_ZERO: cond_hit = err_zero;
			asf1d_pkg::COND_NO_RAMP:  cond_hit = no_ramp;
			asf1d_pkg::COND_DIV_MORE: cond_hit = div_more;
			asf1d_pkg::COND_OUT_FREE: cond_hit = out_free;
			default:                  cond_hit = 1'b1;
		endcase
	end

	// sequencer, architectural state, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= asf1d_pkg::S_WAIT;
			ms_q        <= asf1d_pkg::MAX_SPEED_RST;
			mf_q        <= asf1d_pkg::MAX_FORCE_RST;
			dd_q        <= asf1d_pkg::DAMPING_RST;
			pos_q       <= '0;
			vel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= cond_hit ? uw.nxt_t : uw.nxt_f;
			if (cfg_valid) begin
				unique case (cfg_index)
					asf1d_pkg::REG_MAX_SPEED: ms_q <= cfg_data;
					asf1d_pkg::REG_MAX_FORCE: mf_q <= cfg_data;
					asf1d_pkg::REG_DAMPING:   dd_q <= cfg_data[DmW-1:0];
					default: ;
				endcase
			end
			case (uw.op)
				asf1d_pkg::OP_RESTART: begin
					if (restart_q) begin
						pos_q <= target_q;
						vel_q <= '0;
					end
				end
				asf1d_pkg::OP_VEL:  vel_q <= vel_lim[PW-1:0];
				asf1d_pkg::OP_POS:  pos_q <= pos_next;
				asf1d_pkg::OP_SNAP: pos_q <= target_q;
				default: ;
			endcase
			if (uw.op == asf1d_pkg::OP_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			target_q  <= target_position;
			restart_q <= restart;
		end
		case (uw.op) inside
			asf1d_pkg::OP_ERR: err_q <= {target_q[PW-1], target_q} - {pos_q[PW-1], pos_q};
			asf1d_pkg::OP_MUL: prod_q <= ProdW'(ms_q) * ProdW'(aerr);
			asf1d_pkg::OP_DIVINIT: begin
				rem_q <= prod_hi_ext[DdW-1:0];
				shr_q <= prod_q[QW-1:0];
				quo_q <= '0;
				cnt_q <= CntW'(QW);
			end
			asf1d_pkg::OP_DIVSTEP: begin
				rem_q <= div_ge ? div_sub[DdW-1:0] : div_try[DdW-1:0];
				shr_q <= {shr_q[QW-2:0], 1'b0};
				quo_q <= {quo_q[QW-2:0], div_ge};
				cnt_q <= cnt_q - CntW'(1);
			end
			asf1d_pkg::OP_DESRAMP, asf1d_pkg::OP_DESMAX: des_q <= des_next;
			asf1d_pkg::OP_STEER: steer_q <= steer_lim[PW-1:0];
			default: ;
		endcase
		if (uw.op == asf1d_pkg::OP_OUT && out_free)
			out_q <= pos_q;
	end

endmodule

[sv/asf1d_checker.sv]
// Port-level checker for the arrive follower and its bind.
`timescale 1ns / 1ps

module asf1d_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [asf1d_pkg::POS_W-1:0] position_out,
	input logic                               cfg_ready
);

	// held result stays put until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position_out))
		else $error("result changed while stalled");

	// one item in flight: input closes right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a new result only appears at the end of a tick's work
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised without work in flight");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind arrive_steering_follower_1d asf1d_checker u_asf1d_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.position_out (position_out),
	.cfg_ready    (cfg_ready)
);

[tb/tb.sv]
// Self-checking testbench for the 1-D arrive steering follower.
`timescale 1ns / 1ps

module tb;

	localparam int FRAC = asf1d_pkg::FRACTION_BITS_DEF;
	localparam logic [asf1d_pkg::IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam longint POS_HI = 64'sd2147483647;
	localparam longint POS_LO = -64'sd2147483648;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_PHASES = 10;
	localparam int TICKS_PER_PHASE = 133;

	typedef struct packed {
		logic signed [asf1d_pkg::POS_W-1:0] target;
		logic                               restart;
	} tick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [asf1d_pkg::POS_W-1:0] target_position = '0;
	logic restart = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [asf1d_pkg::POS_W-1:0] position_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [asf1d_pkg::IDX_W-1:0] cfg_index = '0;
	logic [asf1d_pkg::SPEED_W-1:0] cfg_data = '0;

	tick_t pending_ticks[$];
	logic signed [asf1d_pkg::POS_W-1:0] expected_positions[$];

	// follower state and register copies
	longint follow_pos = 0;
	longint follow_vel = 0;
	longint lim_speed = asf1d_pkg::MAX_SPEED_RST;
	longint lim_force = asf1d_pkg::MAX_FORCE_RST;
	longint lim_damping = asf1d_pkg::DAMPING_RST;

	int error_count = 0;
	int quiet = 0;
	bit no_idle = 1'b0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	arrive_steering_follower_1d dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.target_position (target_position),
		.restart         (restart),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.position_out    (position_out),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic longint magnitude(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint apply_sign(input longint s, input longint m);
		if (s > 0)
			return m;
		if (s < 0)
			return -m;
		return 0;
	endfunction

	// one follower tick; updates the tracked position and velocity
	function automatic logic signed [asf1d_pkg::POS_W-1:0] follow_tick(
			input logic signed [asf1d_pkg::POS_W-1:0] tgt, input logic rst);
		longint err, desired, steer, v, p, span;
		if (rst) begin
			follow_pos = tgt;
			follow_vel = 0;
		end
		err = tgt - follow_pos;
		if (err == 0) begin
			follow_pos = tgt;
		end else begin
			span = lim_damping << FRAC;
			if (span != 0 && magnitude(err) < span)
				desired = apply_sign(err, lim_speed * magnitude(err) / span);
			else
				desired = apply_sign(err, lim_speed);
			steer = desired - follow_vel;
			if (magnitude(steer) >= lim_force)
				steer = apply_sign(steer, lim_force);
			v = follow_vel + steer;
			if (magnitude(v) >= lim_speed)
				v = apply_sign(v, lim_speed);
			follow_vel = v;
			p = follow_pos + v;
			if (p > POS_HI)
				p = POS_HI;
			if (p < POS_LO)
				p = POS_LO;
			follow_pos = p;
		end
		return follow_pos[asf1d_pkg::POS_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $realtime, msg);
		error_count++;
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin : drive_blk
		tick_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			target_position <= '0;
			restart <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_positions.push_back(follow_tick(target_position, restart));
			if (!in_valid || in_ready) begin
				if (pending_ticks.size() != 0 && (no_idle || $urandom_range(0, 99) >= 8)) begin
					nxt = pending_ticks.pop_front();
					in_valid <= 1'b1;
					target_position <= nxt.target;
					restart <= nxt.restart;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin : sink_blk
		logic signed [asf1d_pkg::POS_W-1:0] want;
		logic stall;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_served <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_positions.size() == 0) begin
					report_mismatch($sformatf("position_out %0d with no tick pending", position_out));
				end else begin
					want = expected_positions.pop_front();
					if (position_out !== want)
						report_mismatch($sformatf("position_out %0d (0x%08h), expected %0d (0x%08h)",
							position_out, position_out, want, want));
				end
			end
			stall = hold_left != 0 || hold_served != hold_requests ||
				(!no_idle && $urandom_range(0, 99) < 8);
			if (hold_served != hold_requests) begin
				hold_served <= hold_requests;
				hold_left <= HOLD_CYCLES;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
			out_ready <= !stall;
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_tick(input logic signed [asf1d_pkg::POS_W-1:0] t, input logic r);
		pending_ticks.push_back('{target: t, restart: r});
	endtask

	task automatic write_reg(input logic [asf1d_pkg::IDX_W-1:0] idx,
			input logic [asf1d_pkg::SPEED_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			asf1d_pkg::REG_MAX_SPEED: lim_speed = data;
			asf1d_pkg::REG_MAX_FORCE: lim_force = data;
			asf1d_pkg::REG_DAMPING:   lim_damping = data[asf1d_pkg::DAMP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_ticks.size() != 0 || in_valid || expected_positions.size() != 0);
	endtask

	function automatic logic [asf1d_pkg::SPEED_W-1:0] pick_limit();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 31'($urandom_range(1, 255));
			3: return 31'($urandom);
			default: return 31'($urandom_range(1 << 12, 1 << 19));
		endcase
	endfunction

	// mostly restart-then-glide sequences toward an offset target, some noise
	task automatic queue_random(input int count);
		int left, len;
		logic signed [asf1d_pkg::POS_W-1:0] anchor, offset, tgt;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 99) < 10) begin
				queue_tick($urandom, 1'($urandom_range(0, 1)));
				left--;
			end else begin
				if ($urandom_range(0, 2) == 0)
					anchor = $urandom;
				else
					anchor = (($urandom_range(0, 8000) - 4000) << FRAC) | $urandom_range(0, 65535);
				case ($urandom_range(0, 3))
					0: offset = $urandom_range(0, 1023);
					1: offset = $urandom_range(0, 8 << FRAC);
					2: offset = $urandom_range(0, 200 << FRAC);
					default: offset = $urandom;
				endcase
				if ($urandom_range(0, 1))
					offset = -offset;
				len = $urandom_range(4, 30);
				queue_tick(anchor, 1'b1);
				left--;
				tgt = anchor + offset;
				for (int i = 1; i < len && left > 0; i++) begin
					// moving target now and then
					if ($urandom_range(0, 9) == 0)
						tgt = tgt + $urandom_range(0, 4 << FRAC) - (2 << FRAC);
					// stray restart breaks the glide
					queue_tick(tgt, $urandom_range(0, 19) == 0);
					left--;
				end
			end
		end
	endtask

	initial begin
		logic [asf1d_pkg::SPEED_W-1:0] damp_word;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: zero error, ramp, full speed, extreme targets, tiny ramp speed
		queue_tick(32'sd0, 1'b1);
		queue_tick(32'sd0, 1'b0);
		queue_tick(32'sd10 <<< FRAC, 1'b0);
		queue_tick(32'sd10 <<< FRAC, 1'b0);
		queue_tick(32'sd1000 <<< FRAC, 1'b0);
		queue_tick(32'sd1000 <<< FRAC, 1'b0);
		queue_tick(32'h7FFF_FFFF, 1'b1);
		queue_tick(32'h8000_0000, 1'b0);
		queue_tick(32'h8000_0000, 1'b1);
		queue_tick(32'h7FFF_FFFF, 1'b0);
		queue_tick(32'sd1, 1'b1);
		queue_tick(32'sd2, 1'b0);
		drain();

		// full limits, no ramp: overshoot saturates position both ways
		write_reg(asf1d_pkg::REG_MAX_SPEED, '1);
		write_reg(asf1d_pkg::REG_MAX_FORCE, '1);
		write_reg(asf1d_pkg::REG_DAMPING, '0);
		@(negedge clk);
		queue_tick(32'h7FFF_FFFF - 32'd1000, 1'b1);
		queue_tick(32'h7FFF_FFFF, 1'b0);
		queue_tick(32'h8000_0000 + 32'd1000, 1'b1);
		queue_tick(32'h8000_0000, 1'b0);
		drain();

		// zero limits, widest ramp
		write_reg(asf1d_pkg::REG_MAX_SPEED, '0);
		write_reg(asf1d_pkg::REG_MAX_FORCE, '0);
		write_reg(asf1d_pkg::REG_DAMPING, 31'hFFFF);
		@(negedge clk);
		queue_tick(32'sd5 <<< FRAC, 1'b1);
		queue_tick(32'sd100 <<< FRAC, 1'b0);
		drain();

		// zero force only; unmapped index must leave the registers alone
		write_reg(asf1d_pkg::REG_MAX_SPEED, '1);
		write_reg(asf1d_pkg::REG_DAMPING, 31'd1);
		write_reg(REG_UNMAPPED, 31'h5555_5555);
		@(negedge clk);
		queue_tick(32'sd0, 1'b1);
		queue_tick(-(32'sd5 <<< FRAC), 1'b0);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 4))
				0: damp_word = '0;
				1: damp_word = 31'hFFFF;
				2: damp_word = 31'($urandom_range(1, 200));
				default: damp_word = 31'($urandom);
			endcase
			write_reg(asf1d_pkg::REG_MAX_SPEED,
				ph == 0 ? asf1d_pkg::MAX_SPEED_RST : pick_limit());
			write_reg(asf1d_pkg::REG_MAX_FORCE,
				ph == 0 ? asf1d_pkg::MAX_FORCE_RST : pick_limit());
			write_reg(asf1d_pkg::REG_DAMPING,
				ph == 0 ? 31'(asf1d_pkg::DAMPING_RST) : damp_word);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNMAPPED, 31'($urandom));
			@(negedge clk);
			no_idle = (ph == 2);
			queue_random(TICKS_PER_PHASE);
			// receiver holds off in phase 5
			if (ph == 5)
				hold_requests++;
			drain();
		end

		no_idle = 1'b0;
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[arrive_steering_follower_1d.f]
sv/asf1d_pkg.sv
sv/arrive_steering_follower_1d.sv
sv/asf1d_checker.sv
tb/tb.sv
